// File: design/dshot_pkg.sv
// Shared types, constants and functions for the DShot telemetry decoder.
package dshot_pkg;

  localparam int unsigned RawW  = 21;
  localparam int unsigned RpsW  = 20;
  localparam int unsigned PpW   = 6;
  localparam int unsigned StW   = 2;
  localparam int unsigned PerW  = 16;
  localparam int unsigned NumW  = 26;
  localparam logic [NumW-1:0] Dividend = 26'd60000000;
  localparam logic [PpW-1:0]  PpReset  = 6'd6;
  localparam logic [24:0]     Recip15  = 25'd17895698;
  localparam int unsigned     RecipSh  = 28;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ERROR    = 2'd1,
    ST_STOPPED  = 2'd2,
    ST_ZERO_PER = 2'd3
  } status_e;

  typedef struct packed {
    logic [RawW-1:0] raw_frame;
  } in_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [RpsW-1:0] rps;
  } out_t;

  function automatic logic [4:0] gcr_decode(input logic [4:0] code);
    logic [4:0] r;
    begin
      case (code)
        5'd9:  r = 5'd9;
        5'd10: r = 5'd10;
        5'd11: r = 5'd11;
        5'd13: r = 5'd13;
        5'd14: r = 5'd14;
        5'd15: r = 5'd15;
        5'd18: r = 5'd2;
        5'd19: r = 5'd3;
        5'd21: r = 5'd5;
        5'd22: r = 5'd6;
        5'd23: r = 5'd7;
        5'd25: r = 5'd0;
        5'd26: r = 5'd8;
        5'd27: r = 5'd1;
        5'd29: r = 5'd4;
        5'd30: r = 5'd12;
        default: r = 5'h10;
      endcase
      return r;
    end
  endfunction

endpackage

// File: design/dshot_if.sv
// Valid/ready stream interface with a generic payload.
interface dshot_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/dshot_divstage.sv
// One registered restoring-division stage group with its own valid bit and side data.
module dshot_divstage #(
  parameter int unsigned NumW  = 26,
  parameter int unsigned DenW  = 26,
  parameter int unsigned Steps = 4,
  parameter int unsigned SideW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] rem_i,
  input  logic [NumW-1:0] quo_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [SideW-1:0] side_i,
  input  logic [$clog2(NumW+1)-1:0] bit_i,
  output logic            valid_o,
  output logic [NumW-1:0] rem_o,
  output logic [NumW-1:0] quo_o,
  output logic [NumW-1:0] num_o,
  output logic [DenW-1:0] den_o,
  output logic [SideW-1:0] side_o,
  output logic [$clog2(NumW+1)-1:0] bit_o
);
  localparam int unsigned BW = $clog2(NumW+1);
  logic [NumW:0]   r;
  logic [NumW-1:0] q;
  logic [BW-1:0]   b;
  logic [NumW:0]   rem_d;
  logic [NumW-1:0] quo_d;
  logic [BW-1:0]   bit_d;
  logic            valid_q;
  logic [NumW-1:0] rem_q, quo_q, num_q;
  logic [DenW-1:0] den_q;
  logic [SideW-1:0] side_q;
  logic [BW-1:0]   bit_q;

  always_comb begin
    r = {1'b0, rem_i};
    q = quo_i;
    b = bit_i;
    for (int s = 0; s < Steps; s++) begin
      if (b != '0) begin
        b = b - BW'(1);
        r = {r[NumW-1:0], num_i[b[$clog2(NumW)-1:0]]};
        if (r >= (NumW+1)'(den_i)) begin
          r = r - (NumW+1)'(den_i);
          q = {q[NumW-2:0], 1'b1};
        end else begin
          q = {q[NumW-2:0], 1'b0};
        end
      end
    end
    rem_d = r;
    quo_d = q;
    bit_d = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d[NumW-1:0];
      quo_q  <= quo_d;
      num_q  <= num_i;
      den_q  <= den_i;
      side_q <= side_i;
      bit_q  <= bit_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;
  assign bit_o   = bit_q;
endmodule

// File: design/dshot_front.sv
// Front stage: transition decode, GCR lookup, checksum and period extraction.
module dshot_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [dshot_pkg::RawW-1:0]    raw_i,
  output logic                          valid_o,
  output logic [dshot_pkg::StW-1:0]     status_o,
  output logic [dshot_pkg::PerW-1:0]    period_o
);
  localparam int unsigned PerW = dshot_pkg::PerW;

  logic [19:0] bits;
  logic [4:0]  nib [4];
  logic        bad;
  logic [15:0] word;
  logic [11:0] payload;
  logic [dshot_pkg::PerW-1:0] period;
  logic [dshot_pkg::StW-1:0]  status_d;
  logic        valid_q;
  logic [dshot_pkg::StW-1:0]  status_q;
  logic [dshot_pkg::PerW-1:0] period_q;

  always_comb begin
    bits = raw_i[19:0] ^ raw_i[20:1];
    bad  = 1'b0;
    for (int g = 0; g < 4; g++) begin
      nib[g] = dshot_pkg::gcr_decode(bits[5*g +: 5]);
      bad = bad | nib[g][4];
    end
    word = {nib[3][3:0], nib[2][3:0], nib[1][3:0], nib[0][3:0]};
    if ((word[3:0] ^ word[7:4] ^ word[11:8] ^ word[15:12]) != 4'hF) begin
      bad = 1'b1;
    end
    payload = word[15:4];
    period  = PerW'({7'd0, payload[8:0]} << payload[11:9]);
    if (bad) begin
      status_d = dshot_pkg::ST_ERROR;
    end else if (payload == 12'hFFF) begin
      status_d = dshot_pkg::ST_STOPPED;
    end else if (period == '0) begin
      status_d = dshot_pkg::ST_ZERO_PER;
    end else begin
      status_d = dshot_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_q <= status_d;
      period_q <= (status_d == dshot_pkg::ST_OK) ? period : PerW'(1);
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign period_o = period_q;
endmodule

// File: design/dshot_divpipe.sv
// Pipelined unsigned divider built from registered stage groups.
module dshot_divpipe #(
  parameter int unsigned NumW  = 26,
  parameter int unsigned DenW  = 26,
  parameter int unsigned Steps = 4,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);
  localparam int unsigned Stages = (NumW + Steps - 1) / Steps;
  localparam int unsigned BW = $clog2(NumW+1);

  logic             v   [Stages+1];
  logic [NumW-1:0]  rem [Stages+1];
  logic [NumW-1:0]  quo [Stages+1];
  logic [NumW-1:0]  num [Stages+1];
  logic [DenW-1:0]  den [Stages+1];
  logic [SideW-1:0] sd  [Stages+1];
  logic [BW-1:0]    bt  [Stages+1];

  assign v[0]   = valid_i;
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign num[0] = num_i;
  assign den[0] = den_i;
  assign sd[0]  = side_i;
  assign bt[0]  = BW'(NumW);

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    dshot_divstage #(
      .NumW(NumW), .DenW(DenW), .Steps(Steps), .SideW(SideW)
    ) u_stage (
      .clk_i, .rst_ni, .en_i,
      .valid_i(v[i]), .rem_i(rem[i]), .quo_i(quo[i]), .num_i(num[i]),
      .den_i(den[i]), .side_i(sd[i]), .bit_i(bt[i]),
      .valid_o(v[i+1]), .rem_o(rem[i+1]), .quo_o(quo[i+1]), .num_o(num[i+1]),
      .den_o(den[i+1]), .side_o(sd[i+1]), .bit_o(bt[i+1])
    );
  end

  assign valid_o = v[Stages];
  assign quo_o   = quo[Stages];
  assign side_o  = sd[Stages];
endmodule

// File: design/dshot_erpm_telemetry_decode_core.sv
// Top level of the DShot eRPM telemetry decoder.
// The in channel carries one raw 21-bit telemetry frame per transfer; the out
// channel returns one status and rps per frame, in order. The cfg channel
// writes pole_pairs (a value of 0 acts as 1) and is always ready.
// The block is a fixed pipeline: a front stage decodes the GCR groups and the
// checksum, then two pipelined dividers compute 60000000 / P and the division
// by pole_pairs. The division by 60 is a reciprocal multiplication that feeds
// the output register. Each divider resolves four quotient bits per stage.
// One frame per cycle is taken when the output is not stalled.
// The whole pipeline advances only while the output register is empty or is
// being drained, so a stalled receiver freezes every stage and nothing is lost.
// in.ready is low whenever the output holds a result that is not taken.
// Reset clears all valid bits and sets pole_pairs to 6.
module dshot_erpm_telemetry_decode_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  dshot_if.sink   in_i,
  dshot_if.sink   cfg_i,
  dshot_if.source out_o
);
  localparam int unsigned NumW = dshot_pkg::NumW;
  localparam int unsigned StW  = dshot_pkg::StW;

  logic [dshot_pkg::PpW-1:0] pole_pairs_q;
  logic en;
  logic out_valid_q;
  dshot_pkg::out_t out_q;

  logic                       f_valid;
  logic [StW-1:0]             f_status;
  logic [dshot_pkg::PerW-1:0] f_period;
  logic                       d1_valid, d2_valid;
  logic [NumW-1:0]            d1_quo, d2_quo;
  logic [StW-1:0]             d1_st, d2_st;
  logic [NumW-1:0]            erps;
  logic [NumW-1:0]            pp_den;
  logic [48:0]                prod60;

  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_pairs_q <= dshot_pkg::PpReset;
    end else if (cfg_i.valid) begin
      pole_pairs_q <= cfg_i.data;
    end
  end

  dshot_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_i.valid), .raw_i(in_i.data.raw_frame),
    .valid_o(f_valid), .status_o(f_status), .period_o(f_period)
  );

  dshot_divpipe #(.NumW(NumW), .DenW(NumW), .Steps(4), .SideW(StW)) u_div_per (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_valid), .num_i(dshot_pkg::Dividend),
    .den_i(NumW'(f_period)), .side_i(f_status),
    .valid_o(d1_valid), .quo_o(d1_quo), .side_o(d1_st)
  );

  assign erps   = d1_quo + NumW'(50);
  assign pp_den = (pole_pairs_q == '0) ? NumW'(1) : NumW'(pole_pairs_q);

  dshot_divpipe #(.NumW(NumW), .DenW(NumW), .Steps(4), .SideW(StW)) u_div_pp (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d1_valid), .num_i(erps), .den_i(pp_den), .side_i(d1_st),
    .valid_o(d2_valid), .quo_o(d2_quo), .side_o(d2_st)
  );

  // Dividing by 60 is dividing by 4 and then by 15 through its reciprocal.
  assign prod60 = {25'd0, d2_quo[NumW-1:2]} * {24'd0, dshot_pkg::Recip15};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.status <= d2_st;
      out_q.rps    <= (d2_st == dshot_pkg::ST_OK)
                      ? prod60[dshot_pkg::RecipSh +: dshot_pkg::RpsW] : '0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
endmodule

// File: design/dshot_checker.sv
// Port-level assertions for the DShot telemetry decoder, bound to the top level.
module dshot_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input dshot_pkg::out_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rps_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != dshot_pkg::ST_OK |-> out_data.rps == '0)
    else $error("rps nonzero with error status");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_rps_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.rps <= 20'd1000001)
    else $error("rps out of range");
endmodule

bind dshot_erpm_telemetry_decode_core dshot_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);

// File: tb/tb_dshot_erpm_telemetry_decode_core.sv
// Self-checking testbench for the DShot eRPM telemetry decoder.
module tb_dshot_erpm_telemetry_decode_core;
  import dshot_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [RawW-1:0] raw;
    bit              typed;
    status_e         status;
    logic [RpsW-1:0] rps;
  } frame_row_t;

  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseItems = 222;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam logic [7:0] NoNibble = 8'hFF;

  localparam logic [7:0] GcrToNibble [32] = '{
    NoNibble, NoNibble, NoNibble, NoNibble, NoNibble, NoNibble, NoNibble, NoNibble,
    NoNibble, 8'd9, 8'd10, 8'd11, NoNibble, 8'd13, 8'd14, 8'd15,
    NoNibble, NoNibble, 8'd2, 8'd3, NoNibble, 8'd5, 8'd6, 8'd7,
    NoNibble, 8'd0, 8'd8, 8'd1, NoNibble, 8'd4, 8'd12, NoNibble
  };
  localparam logic [4:0] NibbleToGcr [16] = '{
    5'd25, 5'd27, 5'd18, 5'd19, 5'd29, 5'd21, 5'd22, 5'd23,
    5'd26, 5'd9, 5'd10, 5'd11, 5'd30, 5'd13, 5'd14, 5'd15
  };
  localparam logic [PpW-1:0] PhasePoles [NumPhases] = '{
    6'd6, 6'd1, 6'd32, 6'd0, 6'd63, 6'd17
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dshot_if #(.payload_t(in_t))            in_ch ();
  dshot_if #(.payload_t(logic [PpW-1:0])) cfg_ch ();
  dshot_if #(.payload_t(out_t))           out_ch ();

  dshot_erpm_telemetry_decode_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  out_t            pending_decodes [$];
  logic [PpW-1:0]  model_poles = PpReset;
  int unsigned     errors = 0;
  int unsigned     src_idle_pct = 0;
  int unsigned     dst_idle_pct = 0;
  int unsigned     decodes_seen = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     hold_left = 0;
  bit              hold_done = 1'b0;

  function automatic out_t decode_frame(logic [RawW-1:0] raw, logic [PpW-1:0] poles);
    logic [19:0] bits;
    logic [15:0] word;
    logic [7:0]  nib;
    logic [11:0] payload;
    logic [31:0] period;
    logic [31:0] erps;
    logic [31:0] pp;
    bit          bad;
    out_t        res;
    bits = raw[19:0] ^ raw[20:1];
    word = '0;
    bad = 1'b0;
    for (int g = 0; g < 4; g++) begin
      nib = GcrToNibble[bits[5*g +: 5]];
      if (nib == NoNibble) begin
        bad = 1'b1;
      end else begin
        word[4*g +: 4] = nib[3:0];
      end
    end
    if (!bad && (word[3:0] ^ word[7:4] ^ word[11:8] ^ word[15:12]) != 4'hF) begin
      bad = 1'b1;
    end
    res.rps = '0;
    payload = word[15:4];
    if (bad) begin
      res.status = ST_ERROR;
    end else if (payload == 12'hFFF) begin
      res.status = ST_STOPPED;
    end else begin
      period = 32'(payload[8:0]) << payload[11:9];
      if (period == 0) begin
        res.status = ST_ZERO_PER;
      end else begin
        res.status = ST_OK;
        pp = (poles == 0) ? 32'd1 : 32'(poles);
        erps = 32'd60000000 / period + 32'd50;
        res.rps = RpsW'((erps / pp) / 32'd60);
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] checked_word(logic [11:0] payload);
    return {payload, 4'hF ^ payload[11:8] ^ payload[7:4] ^ payload[3:0]};
  endfunction

  function automatic logic [RawW-1:0] encode_frame(logic [15:0] word, logic top);
    logic [19:0]     bits;
    logic [RawW-1:0] raw;
    for (int g = 0; g < 4; g++) begin
      bits[5*g +: 5] = NibbleToGcr[word[4*g +: 4]];
    end
    raw[20] = top;
    for (int i = 19; i >= 0; i--) begin
      raw[i] = bits[i] ^ raw[i+1];
    end
    return raw;
  endfunction

  task automatic send_frame(logic [RawW-1:0] raw);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.raw_frame <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_decodes.push_back(decode_frame(raw, model_poles));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_poles(logic [PpW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    model_poles = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [RawW-1:0] random_frame();
    int unsigned pick;
    logic [15:0] word;
    pick = $urandom_range(99);
    word = checked_word(12'($urandom));
    if (pick < 8) begin
      word = checked_word({3'($urandom), 9'd0});
    end else if (pick < 12) begin
      word = checked_word(12'hFFF);
    end else if (pick < 20) begin
      word[3:0] = word[3:0] ^ 4'($urandom_range(15, 1));
    end else if (pick < 35) begin
      return RawW'($urandom);
    end
    return encode_frame(word, 1'($urandom));
  endfunction

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && decodes_seen >= 30) begin
      out_ch.ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (out_ch.valid && out_ch.ready) begin
      decodes_seen <= decodes_seen + 1;
      if (pending_decodes.size() == 0) begin
        $error("unexpected transfer: status %0d rps %0d", out_ch.data.status, out_ch.data.rps);
        errors++;
      end else begin
        want = pending_decodes.pop_front();
        if (out_ch.data.status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_ch.data.status);
          errors++;
        end
        if (out_ch.data.rps != want.rps) begin
          $error("rps: expected %0d, actual %0d", want.rps, out_ch.data.rps);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    frame_row_t rows [$];
    frame_row_t row;
    logic [RawW-1:0] raw;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rows.push_back('{21'h000000, 1'b1, ST_ERROR, '0});
    rows.push_back('{21'h1FFFFF, 1'b1, ST_ERROR, '0});
    rows.push_back('{21'h0FFFFF, 1'b1, ST_ERROR, '0});
    rows.push_back('{encode_frame(16'hFFF0, 1'b0), 1'b1, ST_STOPPED, '0});
    rows.push_back('{encode_frame(16'hFFF0, 1'b1), 1'b1, ST_STOPPED, '0});
    for (int e = 0; e < 8; e++) begin
      rows.push_back('{encode_frame(checked_word(12'(e << 9)), e[0]), 1'b1, ST_ZERO_PER, '0});
    end
    rows.push_back('{encode_frame(checked_word(12'h001), 1'b0), 1'b0, ST_OK, '0});
    rows.push_back('{encode_frame(checked_word(12'h001), 1'b1), 1'b0, ST_OK, '0});
    rows.push_back('{encode_frame(checked_word(12'hFFE), 1'b0), 1'b0, ST_OK, '0});
    rows.push_back('{encode_frame(checked_word(12'h1FF), 1'b1), 1'b0, ST_OK, '0});
    rows.push_back('{encode_frame(checked_word(12'hE00 | 12'h0AB), 1'b0), 1'b0, ST_OK, '0});
    rows.push_back('{encode_frame(checked_word(12'h555) ^ 16'h0001, 1'b0), 1'b1, ST_ERROR, '0});
    rows.push_back('{encode_frame(16'hFFF1, 1'b1), 1'b1, ST_ERROR, '0});
    raw = encode_frame(checked_word(12'h3A5), 1'b0);
    raw[4:0] = raw[4:0] ^ 5'b11001;
    raw[5] = raw[5];
    rows.push_back('{{raw[20:5], 5'd0}, 1'b0, ST_OK, '0});
    raw = encode_frame(16'h0000, 1'b0);
    rows.push_back('{{1'b0, raw[19:5], 5'b00000}, 1'b0, ST_OK, '0});

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      src_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 60 : 0;
      dst_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 25 : 0;
      if (ph != 0) begin
        write_poles(PhasePoles[ph]);
      end
      if (ph == 0) begin
        foreach (rows[i]) begin
          row = rows[i];
          send_frame(row.raw);
          if (row.typed) begin
            pending_decodes[$] = '{status: row.status, rps: row.rps};
          end
        end
      end
      for (int n = 0; n < PhaseItems; n++) begin
        send_frame(random_frame());
      end
      drain();
    end
    write_poles(PpReset);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/dshot_pkg.sv
design/dshot_if.sv
design/dshot_divstage.sv
design/dshot_front.sv
design/dshot_divpipe.sv
design/dshot_erpm_telemetry_decode_core.sv
design/dshot_checker.sv
tb/tb_dshot_erpm_telemetry_decode_core.sv
